// ===== hw/rtl/text_console_character_writer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// text console character writer assertion macros
// concurrent checks clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TCCW_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// request codes, control characters and cell constants of the text console
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;

  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

  localparam int TAB_STEP = 8;

  // what a put request does to the screen
  typedef struct packed {
    logic store;   // write one cell at the cursor row
    logic blank;   // the written cell is a space, not the character
    logic scroll;  // cursor ran off the last row
  } put_ctl_t;

endpackage

// ===== hw/rtl/tccw_cursor.sv =====
// ----------------------------------------------------------------------------
// tccw_cursor
// cursor update for a put request: control codes, wrap and scroll detect
// ----------------------------------------------------------------------------
module tccw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [$clog2(COLUMNS)-1:0] col,
  input  logic [$clog2(ROWS)-1:0]    row,
  input  logic [7:0]                 char_code,
  output logic [$clog2(COLUMNS)-1:0] col_next,
  output logic [$clog2(ROWS)-1:0]    row_next,
  output logic [$clog2(COLUMNS)-1:0] store_col,
  output tccw_pkg::put_ctl_t         ctl
);
  import tccw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic [CW:0] col_ext;
  logic [CW:0] col_inc;
  logic [CW:0] col_tab;
  logic [CW:0] col_new;
  logic        adv_row;

  assign col_ext = {1'b0, col};
  assign col_inc = col_ext + (CW+1)'(1);
  assign col_tab = (col_ext + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_STEP - 1));

  always_comb begin
    ctl       = '0;
    store_col = col;
    col_new   = col_ext;
    adv_row   = 1'b0;
    case (char_code)
      CH_NEWLINE: begin
        col_new = '0;
        adv_row = 1'b1;
      end
      CH_RETURN: begin
        col_new = '0;
      end
      CH_TAB: begin
        if (col_tab >= (CW+1)'(COLUMNS)) begin
          col_new = '0;
          adv_row = 1'b1;
        end else begin
          col_new = col_tab;
        end
      end
      CH_BACKSPACE: begin
        // nothing happens at the left edge
        if (col != '0) begin
          col_new   = col_ext - (CW+1)'(1);
          store_col = col - CW'(1);
          ctl.store = 1'b1;
          ctl.blank = 1'b1;
        end
      end
      default: begin
        ctl.store = 1'b1;
        if (col_inc >= (CW+1)'(COLUMNS)) begin
          col_new = '0;
          adv_row = 1'b1;
        end else begin
          col_new = col_inc;
        end
      end
    endcase

    row_next = row;
    if (adv_row) begin
      if (row == RW'(ROWS - 1)) begin
        ctl.scroll = 1'b1;
      end else begin
        row_next = row + RW'(1);
      end
    end
  end

  assign col_next = col_new[CW-1:0];

endmodule

// ===== hw/rtl/text_console_character_writer_unit.sv =====
// a put that scrolls copies each cell one row up, one cell copied per cycle
// through the single screen ram port pair, then blanks the bottom row one cell
// per cycle; a clear blanks the whole screen and puts the cursor at the home cell;
// one request at a time, the next can be taken in the cycle after the result is posted;
// a result still waiting in the output register holds the sequencer
// after reset a clearing pass fills the screen with 0x0720 and no request is
// taken meanwhile; text_color resets to 0x07
// ----------------------------------------------------------------------------
// text_console_character_writer_unit
// text console engine: screen ram, cursor, scroll and clear sequencer
// ----------------------------------------------------------------------------
`include "text_console_character_writer_unit_defines.svh"

module text_console_character_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_value,
  output logic [10:0] cursor_pos
);
  import tccw_pkg::*;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int IW        = (AW > 11) ? AW : 11;
  localparam int LAST_COPY = CELLS - COLUMNS - 1;
  localparam int BOTTOM    = CELLS - COLUMNS;

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_SCROLL = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_BLANK  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t          state;
  logic [7:0]      text_color;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [AW-1:0]   cnt;
  logic [AW-1:0]   wq_addr;
  logic            wq_valid;
  logic            in_range;
  logic [15:0]     val;
  logic [15:0]     rd_data;
  logic [15:0]     mem [CELLS];

  logic [CW-1:0]   col_next;
  logic [RW-1:0]   row_next;
  logic [CW-1:0]   store_col;
  put_ctl_t        ctl;

  logic            accept;
  logic            slot_free;
  logic [IW-1:0]   idx_w;
  logic            idx_ok;
  logic [AW-1:0]   row_base;
  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   store_addr;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  logic [15:0]     wd;

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .col       (cur_col),
    .row       (cur_row),
    .char_code (char_code),
    .col_next  (col_next),
    .row_next  (row_next),
    .store_col (store_col),
    .ctl       (ctl)
  );

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign idx_w      = IW'(cell_index);
  assign idx_ok     = {1'b0, idx_w} < (IW+1)'(CELLS);
  assign row_base   = AW'(cur_row) * AW'(COLUMNS);
  assign cur_addr   = row_base + AW'(cur_col);
  assign store_addr = row_base + AW'(store_col);
  // scroll reads the cell one row below the one that its data is copied to
  assign rd_addr    = (state == ST_SCROLL) ? (cnt + AW'(COLUMNS)) : idx_w[AW-1:0];

  always_comb begin
    we = 1'b0;
    wa = store_addr;
    wd = {text_color, (ctl.blank ? BLANK_CHAR : char_code)};
    case (state)
      ST_INIT: begin
        we = 1'b1;
        wa = cnt;
        wd = RESET_CELL;
      end
      ST_IDLE: begin
        we = accept && (req_type == REQ_PUT) && ctl.store;
      end
      ST_SCROLL: begin
        we = wq_valid;
        wa = wq_addr;
        wd = rd_data;
      end
      ST_DRAIN: begin
        we = 1'b1;
        wa = wq_addr;
        wd = rd_data;
      end
      ST_BLANK: begin
        we = 1'b1;
        wa = cnt;
        wd = {text_color, BLANK_CHAR};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // screen ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      text_color <= RESET_ATTR;
      cur_col    <= '0;
      cur_row    <= '0;
      cnt        <= '0;
      wq_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        text_color <= cfg_data;
      end
      if ((state == ST_FINISH) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (cnt == AW'(CELLS - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            val      <= '0;
            in_range <= idx_ok;
            wq_valid <= 1'b0;
            case (req_type)
              REQ_PUT: begin
                cur_col <= col_next;
                cur_row <= row_next;
                if (ctl.scroll) begin
                  cnt   <= '0;
                  state <= ST_SCROLL;
                end else begin
                  state <= ST_FINISH;
                end
              end
              REQ_READ: begin
                state <= ST_READ;
              end
              REQ_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                cnt     <= '0;
                state   <= ST_BLANK;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_READ: begin
          if (in_range) begin
            val <= rd_data;
          end
          state <= ST_FINISH;
        end
        ST_SCROLL: begin
          wq_addr  <= cnt;
          wq_valid <= 1'b1;
          if (cnt == AW'(LAST_COPY)) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_DRAIN: begin
          wq_valid <= 1'b0;
          cnt      <= AW'(BOTTOM);
          state    <= ST_BLANK;
        end
        ST_BLANK: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            cell_value <= val;
            cursor_pos <= 11'(cur_addr);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TCCW_ASSERT_HOLDS(a_init_blocks_requests, state == ST_INIT, !in_ready, "request taken during clearing pass")
  `TCCW_ASSERT_HOLDS(a_copy_distance, (state == ST_SCROLL) && wq_valid, rd_addr == wq_addr + AW'(COLUMNS + 1), "scroll copy read and write out of step")
  `TCCW_ASSERT_NEXT(a_clear_starts_home, accept && (req_type == REQ_CLEAR), (state == ST_BLANK) && (cnt == '0) && (cur_col == '0) && (cur_row == '0), "clear did not start at the home cell")
  `TCCW_ASSERT_HOLDS(a_cursor_in_screen, state == ST_IDLE, (cur_row < RW'(ROWS - 1)) || (cur_row == RW'(ROWS - 1)), "cursor row beyond the screen")

endmodule
